// ===== design/wpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wpsd_pkg
// Shared types, codes and tag constants of the WAV PCM stream decoder.
// ----------------------------------------------------------------------------
package wpsd_pkg;

  typedef enum logic [1:0] {
    KindSample = 2'd0,
    KindHeader = 2'd1,
    KindError  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone   = 3'd0,
    ErrRiff   = 3'd1,
    ErrWave   = 3'd2,
    ErrFmt    = 3'd3,
    ErrData   = 3'd4,
    ErrFormat = 3'd5
  } err_e;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam logic [CfgIndexW-1:0] CfgNormalize = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgPeak      = 2'd1;
  localparam logic [15:0] PeakReset = 16'd8192;

  localparam logic [5:0] HeaderLastByte = 6'd43;

  localparam logic [3:0][7:0] TagRiff = {8'h46, 8'h46, 8'h49, 8'h52};
  localparam logic [3:0][7:0] TagWave = {8'h45, 8'h56, 8'h41, 8'h57};
  localparam logic [3:0][7:0] TagFmt  = {8'h20, 8'h74, 8'h6d, 8'h66};
  localparam logic [3:0][7:0] TagData = {8'h61, 8'h74, 8'h61, 8'h64};

  typedef struct packed {
    kind_e              kind;
    err_e               code;
    logic [15:0]        channel;
    logic [31:0]        frame;
    logic signed [31:0] raw;
    logic               last;
    logic [31:0]        rate;
    logic [15:0]        bits;
  } entry_t;

  function automatic err_e tag_check(logic [5:0] pos, logic [7:0] b);
    logic [7:0] expect_byte;
    err_e       code;
    expect_byte = 8'h00;
    code        = ErrNone;
    if (pos <= 6'd3) begin
      expect_byte = TagRiff[pos[1:0]];
      code        = ErrRiff;
    end else if (pos >= 6'd8 && pos <= 6'd11) begin
      expect_byte = TagWave[pos[1:0]];
      code        = ErrWave;
    end else if (pos >= 6'd12 && pos <= 6'd15) begin
      expect_byte = TagFmt[pos[1:0]];
      code        = ErrFmt;
    end else if (pos >= 6'd36 && pos <= 6'd39) begin
      expect_byte = TagData[pos[1:0]];
      code        = ErrData;
    end
    return (code != ErrNone && b != expect_byte) ? code : ErrNone;
  endfunction

endpackage

// ===== design/wpsd_front.sv =====
// ----------------------------------------------------------------------------
// wpsd_front
// Byte parser: header tags and fields, frame count division, sample assembly.
// ----------------------------------------------------------------------------
module wpsd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            start_of_file_i,
  input  logic            q_full_i,
  output logic            push_o,
  output wpsd_pkg::entry_t push_entry_o
);
  import wpsd_pkg::*;

  typedef enum logic [2:0] {
    PhHeader,
    PhData,
    PhIdle,
    PhDivide,
    PhReport
  } phase_e;

  phase_e       phase_q, phase_d;
  logic [5:0]   pos_q, pos_d;
  logic [15:0]  chan_q, chan_d;
  logic [31:0]  rate_q, rate_d;
  logic [15:0]  bits_q, bits_d;
  logic [31:0]  size_q, size_d;
  logic [31:0]  frames_q, frames_d;
  logic [31:0]  asm_q, asm_d;
  logic [1:0]   bis_q, bis_d;
  logic [15:0]  ch_q, ch_d;
  logic [31:0]  fr_q, fr_d;
  logic [31:0]  dq_q, dq_d;
  logic [18:0]  rem_q, rem_d;
  logic [18:0]  div_q, div_d;
  logic [4:0]   cnt_q, cnt_d;

  logic         accept;
  phase_e       eff_phase;
  logic [5:0]   eff_pos;
  err_e         code;
  logic [19:0]  trial;
  logic         ge;
  logic [31:0]  asm_new;
  logic [2:0]   nbytes;
  logic signed [31:0] raw;
  logic         is_last;
  logic         bad_fmt;

  assign in_stall_o = (phase_q == PhDivide) || (phase_q == PhReport) || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign nbytes     = bits_q[5:3];

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    chan_d  = chan_q;
    rate_d  = rate_q;
    bits_d  = bits_q;
    size_d  = size_q;
    frames_d = frames_q;
    asm_d   = asm_q;
    bis_d   = bis_q;
    ch_d    = ch_q;
    fr_d    = fr_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    push_entry_o = '0;

    eff_phase = start_of_file_i ? PhHeader : phase_q;
    eff_pos   = start_of_file_i ? 6'd0 : pos_q;
    code      = tag_check(eff_pos, data_byte_i);
    trial     = {rem_q, dq_q[31]};
    ge        = trial >= {1'b0, div_q};
    asm_new   = asm_q;
    if (bis_q == 2'd0) begin
      asm_new = {24'd0, data_byte_i};
    end else begin
      asm_new[{bis_q, 3'b000} +: 8] = data_byte_i;
    end
    unique case (nbytes)
      3'd1:    raw = {{25{~asm_new[7]}}, asm_new[6:0]};
      3'd2:    raw = {{16{asm_new[15]}}, asm_new[15:0]};
      3'd3:    raw = {{8{asm_new[23]}}, asm_new[23:0]};
      default: raw = asm_new;
    endcase
    is_last = (fr_q == frames_q - 32'd1) && (ch_q == chan_q - 16'd1);
    bad_fmt = (chan_q == 16'd0) ||
              !(bits_q == 16'd8 || bits_q == 16'd16 || bits_q == 16'd24 || bits_q == 16'd32);

    if (phase_q == PhDivide) begin
      rem_d = ge ? 19'(trial - {1'b0, div_q}) : trial[18:0];
      dq_d  = {dq_q[30:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        frames_d = {dq_q[30:0], ge};
        phase_d  = PhReport;
      end
    end else if (phase_q == PhReport) begin
      if (!q_full_i) begin
        push_o                = 1'b1;
        push_entry_o.kind     = KindHeader;
        push_entry_o.code     = ErrNone;
        push_entry_o.channel  = chan_q;
        push_entry_o.frame    = frames_q;
        push_entry_o.rate     = rate_q;
        push_entry_o.bits     = bits_q;
        phase_d = (frames_q != 32'd0) ? PhData : PhIdle;
      end
    end else if (accept) begin
      unique case (eff_phase)
        PhHeader: begin
          phase_d = PhHeader;
          if (code != ErrNone) begin
            push_o            = 1'b1;
            push_entry_o.kind = KindError;
            push_entry_o.code = code;
            phase_d           = PhIdle;
          end else begin
            pos_d = eff_pos + 6'd1;
            if (eff_pos == 6'd22) chan_d = {8'd0, data_byte_i};
            if (eff_pos == 6'd23) chan_d[15:8] = data_byte_i;
            if (eff_pos >= 6'd24 && eff_pos <= 6'd27) begin
              rate_d[{eff_pos[1:0], 3'b000} +: 8] = data_byte_i;
            end
            if (eff_pos == 6'd34) bits_d = {8'd0, data_byte_i};
            if (eff_pos == 6'd35) bits_d[15:8] = data_byte_i;
            if (eff_pos >= 6'd40 && eff_pos <= 6'd43) begin
              size_d[{eff_pos[1:0], 3'b000} +: 8] = data_byte_i;
            end
            if (eff_pos == HeaderLastByte) begin
              if (bad_fmt) begin
                push_o            = 1'b1;
                push_entry_o.kind = KindError;
                push_entry_o.code = ErrFormat;
                phase_d           = PhIdle;
              end else begin
                dq_d    = {data_byte_i, size_q[23:0]};
                rem_d   = '0;
                div_d   = 19'(nbytes) * 19'(chan_q);
                cnt_d   = '0;
                asm_d   = '0;
                bis_d   = '0;
                ch_d    = '0;
                fr_d    = '0;
                phase_d = PhDivide;
              end
            end
          end
        end
        PhData: begin
          asm_d = asm_new;
          if ({1'b0, bis_q} + 3'd1 < nbytes) begin
            bis_d = bis_q + 2'd1;
          end else begin
            bis_d                = 2'd0;
            push_o               = 1'b1;
            push_entry_o.kind    = KindSample;
            push_entry_o.code    = ErrNone;
            push_entry_o.channel = ch_q;
            push_entry_o.frame   = fr_q;
            push_entry_o.raw     = raw;
            push_entry_o.last    = is_last;
            push_entry_o.bits    = bits_q;
            if ({1'b0, ch_q} + 17'd1 >= {1'b0, chan_q}) begin
              ch_d = '0;
              fr_d = fr_q + 32'd1;
            end else begin
              ch_d = ch_q + 16'd1;
            end
            if (is_last) phase_d = PhIdle;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      pos_q    <= '0;
      chan_q   <= '0;
      rate_q   <= '0;
      bits_q   <= '0;
      size_q   <= '0;
      frames_q <= '0;
      asm_q    <= '0;
      bis_q    <= '0;
      ch_q     <= '0;
      fr_q     <= '0;
      cnt_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      chan_q   <= chan_d;
      rate_q   <= rate_d;
      bits_q   <= bits_d;
      size_q   <= size_d;
      frames_q <= frames_d;
      asm_q    <= asm_d;
      bis_q    <= bis_d;
      ch_q     <= ch_d;
      fr_q     <= fr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

endmodule

// ===== design/wpsd_fifo.sv =====
// ----------------------------------------------------------------------------
// wpsd_fifo
// Short transaction queue between parser and sample back end.
// ----------------------------------------------------------------------------
module wpsd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wpsd_pkg::entry_t push_entry_i,
  output logic             full_o,
  output logic             head_valid_o,
  output wpsd_pkg::entry_t head_entry_o,
  input  logic             pop_i
);
  import wpsd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o       = cnt_q == CntW'(Depth);
  assign head_valid_o = cnt_q != '0;
  assign head_entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule

// ===== design/wpsd_back.sv =====
// ----------------------------------------------------------------------------
// wpsd_back
// Sample scaling pipeline: multiply, shift, saturate, result register.
// ----------------------------------------------------------------------------
module wpsd_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wpsd_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [wpsd_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                head_valid_i,
  input  wpsd_pkg::entry_t                    head_entry_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          kind_o,
  output logic [2:0]                          error_code_o,
  output logic [15:0]                         channel_o,
  output logic [31:0]                         frame_index_o,
  output logic signed [31:0]                  raw_sample_o,
  output logic signed [15:0]                  scaled_sample_o,
  output logic                                last_o,
  output logic [31:0]                         sample_rate_o,
  output logic [15:0]                         channel_count_o,
  output logic [15:0]                         bits_per_sample_o,
  output logic [31:0]                         frame_count_o
);
  import wpsd_pkg::*;

  function automatic logic signed [15:0] sat16(logic signed [48:0] v);
    logic signed [15:0] r;
    if (v > 49'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -49'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic               norm_q;
  logic [15:0]        peak_q;
  logic               s1_v_q;
  entry_t             s1_q;
  logic signed [48:0] prod_q;
  logic               out_v_q;
  logic               out_free;
  logic               s1_adv;
  logic signed [48:0] shifted;
  logic signed [15:0] scaled;

  assign out_free = !out_v_q || !out_stall_i;
  assign s1_adv   = s1_v_q && out_free;
  assign pop_o    = head_valid_i && (!s1_v_q || s1_adv);
  assign out_valid_o = out_v_q;

  always_comb begin
    unique case (s1_q.bits[5:3])
      3'd1:    shifted = prod_q >>> 8;
      3'd2:    shifted = prod_q >>> 16;
      3'd3:    shifted = prod_q >>> 24;
      default: shifted = prod_q >>> 32;
    endcase
    scaled = norm_q ? sat16(shifted) : sat16(49'(s1_q.raw));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q  <= 1'b0;
      peak_q  <= PeakReset;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CfgNormalize) norm_q <= cfg_data_i[0];
      if (cfg_we_i && cfg_index_i == CfgPeak) peak_q <= cfg_data_i;
      if (pop_o) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q   <= head_entry_i;
      prod_q <= head_entry_i.raw * $signed({1'b0, peak_q});
    end
    if (s1_adv) begin
      kind_o       <= s1_q.kind;
      error_code_o <= s1_q.code;
      unique case (s1_q.kind)
        KindSample: begin
          channel_o       <= s1_q.channel;
          frame_index_o   <= s1_q.frame;
          raw_sample_o    <= s1_q.raw;
          scaled_sample_o <= scaled;
          last_o          <= s1_q.last;
        end
        KindHeader: begin
          channel_o         <= '0;
          frame_index_o     <= '0;
          raw_sample_o      <= '0;
          scaled_sample_o   <= '0;
          last_o            <= 1'b0;
          sample_rate_o     <= s1_q.rate;
          channel_count_o   <= s1_q.channel;
          bits_per_sample_o <= s1_q.bits;
          frame_count_o     <= s1_q.frame;
        end
        default: begin
          channel_o         <= '0;
          frame_index_o     <= '0;
          raw_sample_o      <= '0;
          scaled_sample_o   <= '0;
          last_o            <= 1'b0;
          sample_rate_o     <= '0;
          channel_count_o   <= '0;
          bits_per_sample_o <= '0;
          frame_count_o     <= '0;
        end
      endcase
    end
  end

endmodule

// ===== design/wav_pcm_stream_decoder.sv =====
// A sample passes the queue, stage-one and output registers after its last
// byte is accepted. Input takes one byte per cycle unless the queue is full;
// the header's final byte starts a restoring frame-count divide, and input
// stalls until the header result is queued. Reset is asynchronous, active
// low, clears parser state, queue and result valid; no clearing pass needed.
// ----------------------------------------------------------------------------
// wav_pcm_stream_decoder
// Byte-serial RIFF/WAVE PCM parser with sample conversion and scaling.
// ----------------------------------------------------------------------------
module wav_pcm_stream_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wpsd_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [wpsd_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            start_of_file_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      kind_o,
  output logic [2:0]                      error_code_o,
  output logic [15:0]                     channel_o,
  output logic [31:0]                     frame_index_o,
  output logic signed [31:0]              raw_sample_o,
  output logic signed [15:0]              scaled_sample_o,
  output logic                            last_o,
  output logic [31:0]                     sample_rate_o,
  output logic [15:0]                     channel_count_o,
  output logic [15:0]                     bits_per_sample_o,
  output logic [31:0]                     frame_count_o
);
  import wpsd_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   head_valid;
  entry_t head_entry;
  logic   pop;

  wpsd_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .data_byte_i,
    .start_of_file_i,
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  wpsd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry),
    .pop_i        (pop)
  );

  wpsd_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .error_code_o,
    .channel_o,
    .frame_index_o,
    .raw_sample_o,
    .scaled_sample_o,
    .last_o,
    .sample_rate_o,
    .channel_count_o,
    .bits_per_sample_o,
    .frame_count_o
  );

endmodule
